FILE: hdl/assert_macros.svh
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NOW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NOW(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/mtep_pkg.sv
`timescale 1ns / 1ps
package mtep_pkg;
    localparam int VlqBitsDef = 28;

    localparam logic [3:0] K_PROGRAM  = 4'd4;
    localparam logic [3:0] K_PRESSURE = 4'd5;
    localparam logic [3:0] K_PITCH    = 4'd6;
    localparam logic [3:0] K_SYSEX    = 4'd7;
    localparam logic [3:0] K_META     = 4'd8;
    localparam logic [3:0] K_UNKNOWN  = 4'd9;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_TEMPO   = 2'd1;
    localparam logic [1:0] E_META    = 2'd2;
    localparam logic [1:0] E_UNKNOWN = 2'd3;

    localparam logic [7:0] META_EOT   = 8'h2F;
    localparam logic [7:0] META_TEMPO = 8'h51;

    // classified byte handed from the front to the back
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       hi;
    } t_beat;

    typedef struct packed {
        logic [27:0] delta_ticks;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [3:0]  event_kind;
        logic [7:0]  meta_kind;
        logic [23:0] tempo_us;
        logic        end_of_track;
        logic [1:0]  error_code;
    } t_result;

    function automatic logic [3:0] classify(input logic [7:0] s);
        logic [3:0] k;
        if (s > 8'hEF && s < 8'hFF) k = K_SYSEX;
        else if (s < 8'h80) k = K_UNKNOWN;
        else if (s == 8'hFF) k = K_META;
        else k = {1'b0, s[6:4]};
        return k;
    endfunction

    function automatic logic meta_known(input logic [7:0] t);
        return t <= 8'h09 || t == 8'h20 || t == 8'h21 || t == META_EOT ||
               t == META_TEMPO || t == 8'h54 || t == 8'h58 || t == 8'h59 || t == 8'h7F;
    endfunction
endpackage

FILE: hdl/midi_track_event_parser.sv
`timescale 1ns / 1ps
// midi track event parser
// s_axis carries one track byte a beat: tdata[7:0] data_byte, tuser[0]
// track_start (clears parser, running status and halt before the byte).
// m_axis gives one beat per finished event; tdata fields low to high:
// delta_ticks 28, status_byte 8, first_data 8, second_data 8, event_kind 4,
// meta_kind 8, tempo_us 24, end_of_track 1, error_code 2 (pad to 96 bits).
// i_cfg_we writes has_delta from i_cfg_wdata; write only while idle.
// throughput: one byte per cycle while m_axis accepts results; a two-entry
// queue sits between the byte intake and the parsing state machine.
// result: the event's last byte passes through the queue, is taken by the
// parsing state machine, and the result beat is registered to m_axis.
// a stalled m_axis keeps its result; the queue fills and s_axis_tready
// drops after two more bytes.
// reset (synchronous, active low) empties the queue, clears all parser
// state and sets has_delta to 1.
// errors halt the parser: bytes are consumed without result until
// a beat with track_start.
module midi_track_event_parser import mtep_pkg::*; #(
    parameter int VLQ_BITS = VlqBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // track_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // fields as in head comment
);
    logic    r_has_delta;
    logic    q_valid, q_ready;
    t_beat   q_beat;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_has_delta <= 1'b1;
        else if (i_cfg_we) r_has_delta <= i_cfg_wdata;
    end

    mtep_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata), .i_start(s_axis_tuser),
        .o_valid(q_valid), .i_ready(q_ready), .o_beat(q_beat)
    );

    mtep_back #(.VLQ_BITS(VLQ_BITS)) u_back (
        .i_clk, .i_rst_n, .i_has_delta(r_has_delta),
        .i_valid(q_valid), .o_ready(q_ready), .i_beat(q_beat),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {5'd0, res.error_code, res.end_of_track, res.tempo_us,
                           res.meta_kind, res.event_kind, res.second_data,
                           res.first_data, res.status_byte, res.delta_ticks};
endmodule

FILE: hdl/mtep_front.sv
`timescale 1ns / 1ps
module mtep_front import mtep_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    input  logic       i_start,
    output logic       o_valid,
    input  logic       i_ready,
    output t_beat      o_beat
);
    // two-entry queue toward the back part
    t_beat      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_beat  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_mem[r_wp] <= '{data: i_data, start: i_start, hi: i_data[7]};
    end
endmodule

FILE: hdl/mtep_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mtep_back import mtep_pkg::*; #(
    parameter int VLQ_BITS = VlqBitsDef
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_has_delta,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_beat   i_beat,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);
    typedef enum logic [3:0] {
        PH_START, PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2,
        PH_MTYPE, PH_MLEN, PH_MSKIP, PH_SLEN, PH_SSKIP
    } t_phase;

    t_phase              r_ph, n_ph, ph;
    logic [7:0]          r_run, n_run, run;
    logic [VLQ_BITS-1:0] r_delta, n_delta, delta;
    logic [7:0]          r_cur, n_cur, cur;
    logic [7:0]          r_hold, n_hold, hold;
    logic [7:0]          r_mt, n_mt, mt;
    logic [VLQ_BITS-1:0] r_left, n_left, left;
    logic [1:0]          r_pidx, n_pidx, pidx;
    logic [23:0]         r_tempo, n_tempo, tempo;
    logic                r_halt, n_halt, halt;
    logic                r_ov;
    t_result             r_res, n_res;
    logic                emit, take;
    logic [7:0]          b;
    logic [3:0]          kind;
    logic [VLQ_BITS-1:0] lenv, dec;

    assign o_ready = !r_ov || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign b       = i_beat.data;

    always_comb begin
        // start beat clears all parser state; has_delta and a pending result stay
        ph = i_beat.start ? PH_START : r_ph;
        run = i_beat.start ? '0 : r_run;
        delta = i_beat.start ? '0 : r_delta;
        cur = i_beat.start ? '0 : r_cur;
        hold = i_beat.start ? '0 : r_hold;
        mt = i_beat.start ? '0 : r_mt;
        left = i_beat.start ? '0 : r_left;
        pidx = i_beat.start ? '0 : r_pidx;
        tempo = i_beat.start ? '0 : r_tempo;
        halt = i_beat.start ? 1'b0 : r_halt;
        n_ph = ph; n_run = run; n_delta = delta; n_cur = cur; n_hold = hold;
        n_mt = mt; n_left = left; n_pidx = pidx; n_tempo = tempo; n_halt = halt;
        emit = 1'b0;
        n_res = '0;
        kind = classify(cur);
        lenv = {left[VLQ_BITS-8:0], b[6:0]};
        dec = left - 1'b1;
        if (!halt) begin
            if (ph == PH_START && !i_has_delta) n_delta = '0;
            case (ph)
                PH_START, PH_STATUS: begin
                    if (ph == PH_START && i_has_delta) begin
                        n_delta = VLQ_BITS'(b[6:0]);
                        n_ph = i_beat.hi ? PH_DELTA : PH_STATUS;
                    end else begin
                        n_cur = i_beat.hi ? b : run;
                        kind = classify(n_cur);
                        if (kind <= K_PITCH) begin
                            if (i_beat.hi) begin
                                n_run = b;
                                n_ph = PH_DATA1;
                            end else begin
                                n_hold = b;
                                if (kind == K_PROGRAM || kind == K_PRESSURE) begin
                                    emit = 1'b1;
                                    n_res.event_kind = kind;
                                    n_res.first_data = b;
                                end else begin
                                    n_ph = PH_DATA2;
                                end
                            end
                        end else if (!i_beat.hi || kind == K_UNKNOWN) begin
                            emit = 1'b1;
                            n_res.event_kind = K_UNKNOWN;
                            n_res.error_code = E_UNKNOWN;
                        end else begin
                            n_left = '0;
                            n_ph = (kind == K_META) ? PH_MTYPE : PH_SLEN;
                        end
                    end
                end
                PH_DELTA: begin
                    n_delta = {delta[VLQ_BITS-8:0], b[6:0]};
                    if (!i_beat.hi) n_ph = PH_STATUS;
                end
                PH_DATA1: begin
                    n_hold = b;
                    if (kind == K_PROGRAM || kind == K_PRESSURE) begin
                        emit = 1'b1;
                        n_res.event_kind = kind;
                        n_res.first_data = b;
                    end else begin
                        n_ph = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    emit = 1'b1;
                    n_res.event_kind = kind;
                    n_res.first_data = hold;
                    n_res.second_data = b;
                end
                PH_MTYPE: begin
                    n_mt = b; n_left = '0; n_pidx = '0; n_tempo = '0;
                    n_ph = PH_MLEN;
                end
                PH_MLEN, PH_SLEN, PH_MSKIP, PH_SSKIP: begin
                    if (ph == PH_MLEN || ph == PH_SLEN) n_left = lenv;
                    else n_left = dec;
                    if (ph == PH_MSKIP && pidx != 2'd3) begin
                        n_tempo = {tempo[15:0], b};
                        n_pidx = pidx + 2'd1;
                    end
                    if ((ph == PH_MLEN || ph == PH_SLEN) && i_beat.hi) begin
                        n_ph = ph;
                    end else if (n_left != '0) begin
                        n_ph = (ph == PH_MLEN || ph == PH_MSKIP) ? PH_MSKIP : PH_SSKIP;
                    end else begin
                        emit = 1'b1;
                        if (ph == PH_SLEN || ph == PH_SSKIP) begin
                            n_res.event_kind = K_SYSEX;
                        end else begin
                            n_res.event_kind = K_META;
                            n_res.meta_kind = mt;
                            if (!meta_known(mt)) n_res.error_code = E_META;
                            else if (mt == META_TEMPO) begin
                                if (n_pidx != 2'd3) n_res.error_code = E_TEMPO;
                                else n_res.tempo_us = n_tempo;
                            end else n_res.end_of_track = (mt == META_EOT);
                        end
                    end
                end
                default: n_ph = PH_START;
            endcase
            if (emit) begin
                n_res.delta_ticks = 28'(n_delta);
                n_res.status_byte = n_cur;
                n_ph = PH_START;
                if (n_res.error_code != E_NONE) n_halt = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_START; r_run <= '0; r_delta <= '0; r_cur <= '0;
            r_hold <= '0; r_mt <= '0; r_left <= '0; r_pidx <= '0;
            r_tempo <= '0; r_halt <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (i_ready) r_ov <= 1'b0;
            if (take) begin
                r_ph <= n_ph; r_run <= n_run; r_delta <= n_delta; r_cur <= n_cur;
                r_hold <= n_hold; r_mt <= n_mt; r_left <= n_left; r_pidx <= n_pidx;
                r_tempo <= n_tempo; r_halt <= n_halt;
                if (emit) r_ov <= 1'b1;
            end
        end
        if (take && emit) r_res <= n_res;
    end

    `ASSERT_CLK(a_halt_err, i_clk, i_rst_n, (take && emit && n_res.error_code != E_NONE) |=> r_halt, "error did not halt")
    `ASSERT_CLK(a_hold_res, i_clk, i_rst_n, (r_ov && !i_ready) |=> (r_ov && $stable(r_res)), "result lost")
    `ASSERT_CLK(a_halt_quiet, i_clk, i_rst_n, (r_halt && !i_beat.start) |-> !emit, "halted emitted")
endmodule

FILE: verif/mtep_event_checker.sv
`timescale 1ns / 1ps
module mtep_event_checker import mtep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic        i_s_tuser,   // track_start
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,   // delta, status, data1, data2, kind, meta, tempo, eot, err
    output int          o_fail_count,
    output int          o_pending,
    output int          o_events,
    output int          o_error_events
);
    typedef enum logic [3:0] {
        ST_START, ST_DELTA, ST_STATUS, ST_DATA1, ST_DATA2,
        ST_MTYPE, ST_MLEN, ST_MSKIP, ST_SLEN, ST_SSKIP
    } t_phase;

    t_phase      phase;
    logic        has_delta;
    logic [7:0]  running_status;
    logic [27:0] delta_sum;
    logic [7:0]  cur_status;
    logic [7:0]  data_hold;
    logic [7:0]  meta_type;
    logic [27:0] bytes_left;
    logic [1:0]  tempo_count;
    logic [23:0] tempo_sum;
    logic        halted;

    t_result expected_events[$];

    function automatic logic [3:0] event_kind_of(input logic [7:0] s);
        if (s >= 8'hF0 && s != 8'hFF) return K_SYSEX;
        if (s == 8'hFF) return K_META;
        if (!s[7]) return K_UNKNOWN;
        return s[7:4] - 4'd8;
    endfunction

    function automatic logic is_known_meta(input logic [7:0] t);
        case (t)
            8'h20, 8'h21, 8'h2F, 8'h51, 8'h54, 8'h58, 8'h59, 8'h7F: return 1'b1;
            default: return t <= 8'h09;
        endcase
    endfunction

    task clear_parser();
        phase = ST_START;
        running_status = '0;
        delta_sum = '0;
        cur_status = '0;
        data_hold = '0;
        meta_type = '0;
        bytes_left = '0;
        tempo_count = '0;
        tempo_sum = '0;
        halted = 1'b0;
    endtask

    task push_event(input logic [3:0] kind, input logic [7:0] d1, input logic [7:0] d2,
                    input logic [7:0] meta, input logic [23:0] tempo, input logic eot,
                    input logic [1:0] err);
        t_result r;
        r.delta_ticks = delta_sum;
        r.status_byte = cur_status;
        r.first_data = d1;
        r.second_data = d2;
        r.event_kind = kind;
        r.meta_kind = meta;
        r.tempo_us = tempo;
        r.end_of_track = eot;
        r.error_code = err;
        expected_events.push_back(r);
        phase = ST_START;
        if (err != E_NONE) halted = 1'b1;
    endtask

    task close_meta();
        if (!is_known_meta(meta_type))
            push_event(K_META, 0, 0, meta_type, 0, 0, E_META);
        else if (meta_type == META_TEMPO && tempo_count < 2'd3)
            push_event(K_META, 0, 0, meta_type, 0, 0, E_TEMPO);
        else if (meta_type == META_TEMPO)
            push_event(K_META, 0, 0, meta_type, tempo_sum, 0, E_NONE);
        else
            push_event(K_META, 0, 0, meta_type, 0, meta_type == META_EOT, E_NONE);
    endtask

    task take_status(input logic [7:0] b);
        logic [3:0] k;
        cur_status = b[7] ? b : running_status;
        k = event_kind_of(cur_status);
        if (k <= K_PITCH) begin
            if (b[7]) begin
                running_status = b;
                phase = ST_DATA1;
            end else begin
                data_hold = b;
                if (k == K_PROGRAM || k == K_PRESSURE) push_event(k, b, 0, 0, 0, 0, E_NONE);
                else phase = ST_DATA2;
            end
        end else if (!b[7] || k == K_UNKNOWN) begin
            push_event(K_UNKNOWN, 0, 0, 0, 0, 0, E_UNKNOWN);
        end else begin
            bytes_left = '0;
            phase = (k == K_META) ? ST_MTYPE : ST_SLEN;
        end
    endtask

    task parse_byte(input logic [7:0] b, input logic track_start);
        logic [3:0] k;
        if (track_start) clear_parser();
        if (!halted) begin
            case (phase)
                ST_START: begin
                    if (!has_delta) begin
                        delta_sum = '0;
                        take_status(b);
                    end else begin
                        delta_sum = {21'd0, b[6:0]};
                        phase = b[7] ? ST_DELTA : ST_STATUS;
                    end
                end
                ST_DELTA: begin
                    delta_sum = {delta_sum[20:0], b[6:0]};
                    if (!b[7]) phase = ST_STATUS;
                end
                ST_STATUS: take_status(b);
                ST_DATA1: begin
                    data_hold = b;
                    k = event_kind_of(cur_status);
                    if (k == K_PROGRAM || k == K_PRESSURE) push_event(k, b, 0, 0, 0, 0, E_NONE);
                    else phase = ST_DATA2;
                end
                ST_DATA2: push_event(event_kind_of(cur_status), data_hold, b, 0, 0, 0, E_NONE);
                ST_MTYPE: begin
                    meta_type = b;
                    bytes_left = '0;
                    tempo_count = '0;
                    tempo_sum = '0;
                    phase = ST_MLEN;
                end
                ST_MLEN, ST_SLEN: begin
                    bytes_left = {bytes_left[20:0], b[6:0]};
                    if (!b[7]) begin
                        if (bytes_left != 0) phase = (phase == ST_MLEN) ? ST_MSKIP : ST_SSKIP;
                        else if (phase == ST_MLEN) close_meta();
                        else push_event(K_SYSEX, 0, 0, 0, 0, 0, E_NONE);
                    end
                end
                ST_MSKIP: begin
                    if (tempo_count < 2'd3) begin
                        tempo_sum = {tempo_sum[15:0], b};
                        tempo_count = tempo_count + 2'd1;
                    end
                    bytes_left = bytes_left - 28'd1;
                    if (bytes_left == 0) close_meta();
                end
                ST_SSKIP: begin
                    bytes_left = bytes_left - 28'd1;
                    if (bytes_left == 0) push_event(K_SYSEX, 0, 0, 0, 0, 0, E_NONE);
                end
                default: phase = ST_START;
            endcase
        end
    endtask

    task check_field(input string name, input logic [27:0] exp_v, input logic [27:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    task check_result(input logic [95:0] d);
        t_result e;
        if (expected_events.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h", $time, d);
            o_fail_count++;
        end else begin
            e = expected_events.pop_front();
            check_field("delta_ticks", e.delta_ticks, d[27:0]);
            check_field("status_byte", e.status_byte, d[35:28]);
            check_field("first_data", e.first_data, d[43:36]);
            check_field("second_data", e.second_data, d[51:44]);
            check_field("event_kind", e.event_kind, d[55:52]);
            check_field("meta_kind", e.meta_kind, d[63:56]);
            check_field("tempo_us", e.tempo_us, d[87:64]);
            check_field("end_of_track", e.end_of_track, d[88]);
            check_field("error_code", e.error_code, d[90:89]);
            o_events++;
            if (e.error_code != E_NONE) o_error_events++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_events = 0;
        o_error_events = 0;
        has_delta = 1'b1;
        clear_parser();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            has_delta = 1'b1;
            expected_events.delete();
        end else begin
            if (i_cfg_we) has_delta = i_cfg_wdata;
            if (i_m_tvalid && i_m_tready) check_result(i_m_tdata);
            if (i_s_tvalid && i_s_tready) parse_byte(i_s_tdata, i_s_tuser);
        end
        o_pending = expected_events.size();
    end
endmodule

FILE: verif/midi_track_event_parser_tb.sv
`timescale 1ns / 1ps
module midi_track_event_parser_tb;
    import mtep_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tuser;   // track_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // delta, status, data1, data2, kind, meta, tempo, eot, err

    int fail_count, pending, events_seen, error_events;
    int bytes_sent;
    int cycle_count;
    logic has_delta_now;
    logic start_next;      // track_start rides on the next beat
    logic running_ok;      // a channel status has been seen since the last track_start

    midi_track_event_parser dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    mtep_event_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_events(events_seen), .o_error_events(error_events)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 600000);
        $display("timeout");
        $display("midi_track_event_parser_tb NOT OK");
        $finish;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // receiver: random stalls, plus one long hold-off to back up the byte queue
    initial begin
        int hold;
        m_axis_tready = 1'b0;
        hold = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (cycle_count >= 1500 && cycle_count < 1800) begin
                m_axis_tready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 9) < 2) begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task send_byte(input logic [7:0] b);
        int gap;
        bit taken;
        case ($urandom_range(0, 19))
            0:       gap = $urandom_range(10, 40);
            1, 2, 3, 4, 5, 6: gap = $urandom_range(1, 3);
            default: gap = 0;
        endcase
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= start_next;
        if (start_next) running_ok = 1'b0;
        start_next = 1'b0;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        bytes_sent++;
    endtask

    task send_vlq(input logic [27:0] v);
        logic [6:0] grp[$];
        logic [27:0] r;
        r = v;
        do begin
            grp.push_front(r[6:0]);
            r = r >> 7;
        end while (r != 0);
        while (grp.size() > 1) send_byte({1'b1, grp.pop_front()});
        send_byte({1'b0, grp.pop_front()});
    endtask

    // five groups: the top bits fall off the 28-bit accumulator
    task send_wrapping_vlq();
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h00);
    endtask

    task send_delta();
        if (has_delta_now) begin
            case ($urandom_range(0, 19))
                0:       send_vlq(28'($urandom_range(0, 28'hFFFFFFF)));
                1:       send_wrapping_vlq();
                2:       send_vlq(28'($urandom_range(128, 20000)));
                default: send_vlq(28'($urandom_range(0, 127)));
            endcase
        end
    endtask

    task send_channel(input logic [2:0] grp, input bit running, input logic [7:0] d1,
                      input logic [7:0] d2);
        send_delta();
        if (!running) begin
            send_byte({1'b1, grp, 4'($urandom_range(0, 15))});
            running_ok = 1'b1;
        end
        send_byte(d1);
        if (grp != 3'd4 && grp != 3'd5) send_byte(d2);
    endtask

    // sysex or meta body: length, optionally padded with an empty leading group
    task send_len_payload(input int len, input bit pad, input logic [23:0] lead);
        if (pad) send_byte(8'h80);
        send_vlq(28'(len));
        for (int i = 0; i < len; i++)
            send_byte(i < 3 ? lead[23 - 8*i -: 8] : 8'($urandom));
    endtask

    task send_meta(input logic [7:0] mtype, input int len, input logic [23:0] lead);
        send_delta();
        send_byte(8'hFF);
        send_byte(mtype);
        send_len_payload(len, $urandom_range(0, 7) == 0, lead);
    endtask

    task send_sysex(input logic [7:0] st, input int len);
        send_delta();
        send_byte(st);
        send_len_payload(len, $urandom_range(0, 7) == 0, 24'($urandom));
    endtask

    function automatic logic [7:0] data_value();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
    endfunction

    task random_event();
        logic [7:0] known_types[13];
        logic [7:0] mt;
        int r;
        known_types = '{8'h00, 8'h01, 8'h03, 8'h09, 8'h20, 8'h21, 8'h2F, 8'h51, 8'h51,
                        8'h54, 8'h58, 8'h59, 8'h7F};
        if ($urandom_range(0, 29) == 0) start_next = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            if (running_ok && $urandom_range(0, 2) == 0)
                send_channel(3'($urandom_range(0, 6)), 1'b1, 8'($urandom_range(0, 127)),
                             data_value());
            else
                send_channel(3'($urandom_range(0, 6)), 1'b0, data_value(), data_value());
        end else if (r < 78) begin
            mt = ($urandom_range(0, 9) == 0) ? 8'($urandom) : known_types[$urandom_range(0, 12)];
            if (mt == META_TEMPO)
                send_meta(mt, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 3,
                          24'($urandom));
            else
                send_meta(mt, $urandom_range(0, 5), 24'($urandom));
            if (!(mt <= 8'h09 || mt inside {8'h20, 8'h21, 8'h2F, 8'h51, 8'h54, 8'h58,
                                            8'h59, 8'h7F}) || mt == META_TEMPO)
                start_next = 1'b1;
        end else if (r < 92) begin
            send_sysex(8'($urandom_range(8'hF0, 8'hFE)), $urandom_range(0, 6));
        end else begin
            // noise: raw bytes, then a fresh track to recover
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            start_next = 1'b1;
        end
    endtask

    task drain_and_set(input logic v);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        has_delta_now = v;
        start_next = 1'b1;
    endtask

    task directed_events();
        start_next = 1'b1;
        send_delta();
        send_byte(8'h40);                              // data byte with no running status
        send_byte(8'h00);                              // ignored while halted
        start_next = 1'b1;
        if (has_delta_now) send_vlq(28'hFFFFFFF);
        send_byte(8'h90);
        send_byte(8'h7F);
        send_byte(8'hFF);                              // data with top bit set
        send_channel(3'd1, 1'b1, 8'h00, 8'h00);        // running status
        send_channel(3'd0, 1'b0, 8'h3C, 8'h40);
        send_channel(3'd2, 1'b0, 8'h01, 8'h02);
        send_channel(3'd3, 1'b0, 8'h07, 8'h7F);
        send_channel(3'd4, 1'b0, 8'h05, 8'h00);
        send_channel(3'd5, 1'b1, 8'h33, 8'h00);        // running program-like
        send_channel(3'd6, 1'b0, 8'h7F, 8'h7F);
        send_meta(META_TEMPO, 3, 24'hFFFFFF);
        send_meta(META_TEMPO, 5, 24'h07A120);
        send_meta(8'h03, 0, 24'h0);
        send_sysex(8'hF0, 0);
        send_sysex(8'hF7, 2);
        send_delta();                                  // length that wraps to zero
        send_byte(8'hF0);
        send_byte(8'h81);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h00);
        send_meta(META_EOT, 0, 24'h0);
        send_meta(8'h7E, 1, 24'h0);                    // unknown meta type
        start_next = 1'b1;
        send_meta(META_TEMPO, 2, 24'h123456);          // tempo too short
        start_next = 1'b1;
    endtask

    task random_phase(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) random_event();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cycle_count = 0;
        bytes_sent = 0;
        has_delta_now = 1'b1;
        start_next = 1'b1;
        running_ok = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_events();
        random_phase(800);
        drain_and_set(1'b0);
        directed_events();
        random_phase(500);
        drain_and_set(1'b1);
        random_phase(450);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d track bytes over three delta settings, checked %0d events",
                 bytes_sent, events_seen);
        $display("%0d of them error events", error_events);
        if (fail_count == 0 && pending == 0) begin
            $display("midi_track_event_parser_tb OK");
        end else begin
            $display("midi_track_event_parser_tb NOT OK");
        end
        $finish;
    end
endmodule
